### hw/rtl/ipsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsf_pkg
// Shared constants, codes and types for the IPv4 sort and filter core.
// ----------------------------------------------------------------------------
package ipsf_pkg;

  localparam int DEF_CAPACITY = 64;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_CLEAR = 2'd1;
  localparam logic [1:0] FUNC_EMIT  = 2'd2;

  localparam logic [1:0] MODE_ALL       = 2'd0;
  localparam logic [1:0] MODE_FIRST     = 2'd1;
  localparam logic [1:0] MODE_FIRST_TWO = 2'd2;
  localparam logic [1:0] MODE_ANY       = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EMIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctl_t;

endpackage
`default_nettype wire

### hw/rtl/ipsf_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsf_cell
// One slot of the sorted chain. On a load it keeps, takes the new address or
// takes its upper neighbour; during emit it takes its lower neighbour, the
// tail slot wrapping round to the head.
// ----------------------------------------------------------------------------
module ipsf_cell (
  input  wire               clk,
  input  ipsf_pkg::cell_ctl_t ctl,
  input  wire  [31:0]       ins_address,
  input  wire               valid,
  input  wire               prev_ge,
  input  wire  [31:0]       prev_data,
  input  wire  [31:0]       next_data,
  input  wire  [31:0]       head_data,
  input  wire               is_tail,
  output logic [31:0]       data,
  output logic              ge
);

  assign ge = valid && (data >= ins_address);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (!ge) begin
        data <= prev_ge ? ins_address : prev_data;
      end
    end else if (ctl.rotate) begin
      data <= is_tail ? head_data : next_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/ipsf_match.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipsf_match
// Octet filter applied to the address at the head of the chain.
// ----------------------------------------------------------------------------
module ipsf_match (
  input  wire  [31:0] address,
  input  wire  [1:0]  filter_mode,
  input  wire  [7:0]  octet_first,
  input  wire  [7:0]  octet_second,
  output logic        hit
);

  logic eq0, eq1;

  assign eq0 = address[31:24] == octet_first;
  assign eq1 = address[23:16] == octet_second;

  always_comb begin
    case (filter_mode)
      ipsf_pkg::MODE_ALL:       hit = 1'b1;
      ipsf_pkg::MODE_FIRST:     hit = eq0;
      ipsf_pkg::MODE_FIRST_TWO: hit = eq0 && eq1;
      ipsf_pkg::MODE_ANY:       hit = eq0 || (address[23:16] == octet_first) ||
                                      (address[15:8] == octet_first) ||
                                      (address[7:0] == octet_first);
      default:                  hit = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

### hw/rtl/ipsf_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_sort_filter_core
// Sorted store of IPv4 addresses (descending) with filtered read-out.
//
// Commands are taken when start is high and busy is low; func selects load,
// clear or emit, the other fields are the operands.
// Load: every cell compares the new address with its own entry in
//   parallel and the chain opens a gap in a single shift, so loads may follow
//   back to back. A load into a full store is dropped and sets overflow.
// Clear: overflow stays set until reset.
// Emit: busy in the EMIT and FINISH states; an empty store skips EMIT.
//   The chain rotates one cell per cycle past the filter at the head; one
//   matching entry is held back so that the final one can carry last. Results
//   appear on out_address/last/no_match with result_strobe high for one cycle
//   each. An emit with no match gives one result with no_match and last set.
// overflow shows the sticky flag at all times.
// Reset empties the store and clears overflow. The receiver cannot stall.
// ----------------------------------------------------------------------------
module ipv4_sort_filter_core #(
  parameter int CAPACITY = ipsf_pkg::DEF_CAPACITY
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  func,
  input  wire  [31:0] address,
  input  wire  [1:0]  filter_mode,
  input  wire  [7:0]  octet_first,
  input  wire  [7:0]  octet_second,
  output logic        result_strobe,
  output logic [31:0] out_address,
  output logic        last,
  output logic        no_match,
  output logic        overflow
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  ipsf_pkg::state_t    state, state_next;
  ipsf_pkg::cell_ctl_t ctl;

  logic [CNT_W-1:0] count;
  logic             overflow_flag;
  logic [IDX_W-1:0] idx;
  logic [1:0]       mode;
  logic [7:0]       oct1, oct2;
  logic             pending_valid;
  logic [31:0]      pending_address;

  logic [31:0] cell_data [CAPACITY];
  logic        cell_ge   [CAPACITY];

  logic accept, full, last_step, hit;

  assign full      = count == CNT_W'(CAPACITY);
  assign last_step = (CNT_W'(idx) + CNT_W'(1)) == count;
  assign overflow  = overflow_flag;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic        prev_ge;
      logic [31:0] prev_data;
      logic [31:0] next_data;
      if (i == 0) begin : g_first
        assign prev_ge   = 1'b1;
        assign prev_data = '0;
      end else begin : g_mid
        assign prev_ge   = cell_ge[i-1];
        assign prev_data = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_end
        assign next_data = cell_data[0];
      end else begin : g_nxt
        assign next_data = cell_data[i+1];
      end
      ipsf_cell u_cell (
        .clk         (clk),
        .ctl         (ctl),
        .ins_address (address),
        .valid       (CNT_W'(i) < count),
        .prev_ge     (prev_ge),
        .prev_data   (prev_data),
        .next_data   (next_data),
        .head_data   (cell_data[0]),
        .is_tail     (CNT_W'(i + 1) == count),
        .data        (cell_data[i]),
        .ge          (cell_ge[i])
      );
    end
  endgenerate

  ipsf_match u_match (
    .address      (cell_data[0]),
    .filter_mode  (mode),
    .octet_first  (oct1),
    .octet_second (oct2),
    .hit          (hit)
  );

  always_comb begin
    state_next = state;
    case (state)
      ipsf_pkg::ST_IDLE: begin
        if (accept && func == ipsf_pkg::FUNC_EMIT) begin
          state_next = (count == '0) ? ipsf_pkg::ST_FINISH : ipsf_pkg::ST_EMIT;
        end
      end
      ipsf_pkg::ST_EMIT: begin
        if (last_step) begin
          state_next = ipsf_pkg::ST_FINISH;
        end
      end
      ipsf_pkg::ST_FINISH: state_next = ipsf_pkg::ST_IDLE;
      default:             state_next = ipsf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = state != ipsf_pkg::ST_IDLE;
    accept     = start && !busy;
    ctl.load   = accept && func == ipsf_pkg::FUNC_LOAD && !full;
    ctl.rotate = state == ipsf_pkg::ST_EMIT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ipsf_pkg::ST_IDLE;
      count         <= '0;
      overflow_flag <= 1'b0;
      pending_valid <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      result_strobe <= (state == ipsf_pkg::ST_EMIT && hit && pending_valid) ||
                       state == ipsf_pkg::ST_FINISH;
      if (accept) begin
        case (func)
          ipsf_pkg::FUNC_LOAD: begin
            if (full) begin
              overflow_flag <= 1'b1;
            end else begin
              count <= count + CNT_W'(1);
            end
          end
          ipsf_pkg::FUNC_CLEAR: count <= '0;
          ipsf_pkg::FUNC_EMIT: begin
            mode          <= filter_mode;
            oct1          <= octet_first;
            oct2          <= octet_second;
            idx           <= '0;
            pending_valid <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state == ipsf_pkg::ST_EMIT) begin
        idx <= idx + IDX_W'(1);
        if (hit) begin
          if (pending_valid) begin
            out_address   <= pending_address;
            last          <= 1'b0;
            no_match      <= 1'b0;
          end
          pending_address <= cell_data[0];
          pending_valid   <= 1'b1;
        end
      end
      if (state == ipsf_pkg::ST_FINISH) begin
        out_address   <= pending_valid ? pending_address : '0;
        last          <= 1'b1;
        no_match      <= !pending_valid;
      end
    end
  end

endmodule
`default_nettype wire
